// ===== hdl/rupd_pkg.sv =====
`timescale 1ns / 1ps
package rupd_pkg;

	// Sizes of the plane that the block is built for by default.
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	// Configuration register file.
	localparam int CFG_DATA_W = 11;
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_PLANE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_PLANE_HEIGHT = 1'b1;
	localparam logic [CFG_DATA_W-1:0]  PLANE_WIDTH_RST  = 11'd1024;
	localparam logic [CFG_DATA_W-1:0]  PLANE_HEIGHT_RST = 11'd1024;

	// Key byte layout: bit 7 selects a residual run, the low bits give its length.
	localparam int KEY_LITERAL_BIT = 7;
	localparam logic [6:0] KEY_LENGTH_MASK = 7'h7f;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       restart;
	} in_word_t;

	typedef struct packed {
		logic [7:0] pixel_first;
		logic [7:0] pixel_second;
		logic [1:0] pixel_count;
		logic [9:0] column;
		logic [9:0] row;
		logic       last_of_run;
		logic       plane_done;
		logic       error;
	} out_word_t;

endpackage

// ===== hdl/rupd_if.sv =====
`timescale 1ns / 1ps

// Channel that carries coded bytes into the decoder.
interface rupd_in_if;
	logic               valid;
	logic               ready;
	rupd_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Channel that carries decoded pixel words out of the decoder.
interface rupd_out_if;
	logic                valid;
	logic                ready;
	rupd_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/rupd_ram.sv =====
`timescale 1ns / 1ps
module rupd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = rupd_pkg::DEF_MAX_WIDTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/rle_up_prediction_plane_decoder_core.sv =====
`timescale 1ns / 1ps
// Run-length plane decoder with up prediction for one 8-bit plane. Coded bytes enter
// on the code channel one word at a time; decoded pixels leave on the pixels channel as
// words of up to two pixels of one row with their column and row. The block works on one
// coded byte at a time and holds code.ready low until that byte is finished. All pixel
// work goes through a line store with one read and one write port that is read and then
// written once for each pixel. A copy-run key is worked as pixel pairs, with a lone pixel
// at a row end or run end, and a stall on the pixels channel holds the block until its
// word can be loaded. The output word is registered, so the next byte is taken while the
// last word still waits. The line store is not cleared after reset: the first row predicts
// from zero and every later row reads only columns that the row above wrote, as long as
// the plane width does not grow within a plane.
module rle_up_prediction_plane_decoder_core #(
	parameter int MAX_WIDTH  = rupd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rupd_pkg::DEF_MAX_HEIGHT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [rupd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [rupd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	rupd_in_if.sink                            code,
	rupd_out_if.source                         pixels
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int CW1 = $clog2(MAX_WIDTH + 1);
	localparam int RW1 = $clog2(MAX_HEIGHT + 1);
	localparam int EW  = (CW1 > 8) ? CW1 : 8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_ERR,
		S_RD1,
		S_WR1,
		S_RD2,
		S_WR2,
		S_EMIT
	} state_t;

	state_t                         state_q;
	logic [rupd_pkg::CFG_DATA_W-1:0] width_q;
	logic [rupd_pkg::CFG_DATA_W-1:0] height_q;
	logic [CW-1:0]                  col_q;
	logic [RW1-1:0]                 row_q;
	logic [6:0]                     lit_q;
	logic [6:0]                     rem_q;
	logic [7:0]                     byte_q;
	logic [7:0]                     resid_q;
	logic                           lit_mode_q;
	logic                           pair_q;
	logic [7:0]                     p1_q;
	logic [7:0]                     p2_q;
	logic                           out_valid_q;
	rupd_pkg::out_word_t            out_data_q;

	logic [CW1-1:0] eff_w;
	logic [RW1-1:0] eff_h;
	logic           norm;
	logic [6:0]     lit_n;
	logic [EW-1:0]  room;
	logic [EW-1:0]  n_ext;
	logic [EW-1:0]  after;
	logic           key_err;
	logic           slot_free;
	logic           emit_word;
	logic [7:0]     above;
	logic [7:0]     pix;
	logic           pair;
	logic [1:0]     cnt;
	logic [CW1-1:0] col_next;
	logic [RW1-1:0] row_next;
	logic           wrap;
	logic           done;
	logic           ram_we;
	logic [CW-1:0]  ram_waddr;
	logic [CW-1:0]  ram_raddr;
	logic [7:0]     ram_rdata;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rupd_pkg::PLANE_WIDTH_RST;
			height_q <= rupd_pkg::PLANE_HEIGHT_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				rupd_pkg::REG_PLANE_WIDTH:  width_q  <= cfg_wdata;
				rupd_pkg::REG_PLANE_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Plane size in use: zero counts as one, and the size is capped at the build maximum.
	always_comb begin
		if (width_q == '0) begin
			eff_w = CW1'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = CW1'(MAX_WIDTH);
		end else begin
			eff_w = CW1'(width_q);
		end
		if (height_q == '0) begin
			eff_h = RW1'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			eff_h = RW1'(MAX_HEIGHT);
		end else begin
			eff_h = RW1'(height_q);
		end
	end

	// A restart request or a position outside a shrunk plane starts the plane over.
	assign norm  = code.data.restart || (CW1'(col_q) >= eff_w) || (row_q >= eff_h);
	assign lit_n = norm ? 7'd0 : lit_q;

	// Run check for a key: the part past the row edge must be shorter than a row,
	// and a run that wraps needs a row below.
	always_comb begin
		n_ext   = EW'(byte_q[6:0] & rupd_pkg::KEY_LENGTH_MASK);
		room    = EW'(eff_w) - EW'(col_q);
		after   = (n_ext > room) ? (n_ext - room) : '0;
		key_err = (after >= EW'(eff_w)) ||
			((after != '0) && ((row_q + RW1'(1)) >= eff_h));
	end

	// Pixel arithmetic: the pixel above, or zero on the first row, plus the residual.
	assign above = (row_q == '0) ? 8'd0 : ram_rdata;
	assign pix   = above + resid_q;
	assign pair  = !lit_mode_q && (rem_q >= 7'd2) && ((CW1'(col_q) + CW1'(1)) < eff_w);

	// Position step after a word goes out.
	always_comb begin
		cnt      = pair_q ? 2'd2 : 2'd1;
		col_next = CW1'(col_q) + CW1'(cnt);
		wrap     = col_next >= eff_w;
		row_next = row_q + RW1'(1);
		done     = wrap && (row_next >= eff_h);
	end

	// Line store port control: read in the read states, write back in the write states.
	always_comb begin
		ram_we    = (state_q == S_WR1) || (state_q == S_WR2);
		ram_waddr = (state_q == S_WR2) ? (col_q + CW'(1)) : col_q;
		ram_raddr = (state_q == S_RD2) ? (col_q + CW'(1)) : col_q;
	end

	rupd_ram #(
		.WIDTH (8),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (pix),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign slot_free = !out_valid_q || pixels.ready;

	// A new word is loaded into the output register from the error or emit state.
	assign emit_word = ((state_q == S_ERR) || (state_q == S_EMIT)) && slot_free;

	// Sequencer with its position, run counters and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			lit_q       <= '0;
			rem_q       <= '0;
			byte_q      <= '0;
			resid_q     <= '0;
			lit_mode_q  <= 1'b0;
			pair_q      <= 1'b0;
			p1_q        <= '0;
			p2_q        <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (emit_word) begin
				out_valid_q <= 1'b1;
			end else if (pixels.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (code.valid) begin
						byte_q <= code.data.code_byte;
						if (norm) begin
							col_q <= '0;
							row_q <= '0;
							lit_q <= '0;
						end
						if (lit_n != 7'd0) begin
							resid_q    <= code.data.code_byte;
							lit_mode_q <= 1'b1;
							state_q    <= S_RD1;
						end else if ((code.data.code_byte[6:0] &
							rupd_pkg::KEY_LENGTH_MASK) != 7'd0) begin
							state_q <= S_EVAL;
						end
					end
				end
				S_EVAL: begin
					if (key_err) begin
						state_q <= S_ERR;
					end else if (byte_q[rupd_pkg::KEY_LITERAL_BIT]) begin
						lit_q   <= byte_q[6:0] & rupd_pkg::KEY_LENGTH_MASK;
						state_q <= S_IDLE;
					end else begin
						rem_q      <= byte_q[6:0] & rupd_pkg::KEY_LENGTH_MASK;
						resid_q    <= 8'd0;
						lit_mode_q <= 1'b0;
						state_q    <= S_RD1;
					end
				end
				S_ERR: begin
					if (slot_free) begin
						out_data_q.pixel_first  <= 8'd0;
						out_data_q.pixel_second <= 8'd0;
						out_data_q.pixel_count  <= 2'd0;
						out_data_q.column       <= 10'(col_q);
						out_data_q.row          <= 10'(row_q);
						out_data_q.last_of_run  <= 1'b1;
						out_data_q.plane_done   <= 1'b0;
						out_data_q.error        <= 1'b1;
						col_q                   <= '0;
						row_q                   <= '0;
						lit_q                   <= '0;
						state_q                 <= S_IDLE;
					end
				end
				S_RD1: begin
					state_q <= S_WR1;
				end
				S_WR1: begin
					p1_q    <= pix;
					pair_q  <= pair;
					state_q <= pair ? S_RD2 : S_EMIT;
				end
				S_RD2: begin
					state_q <= S_WR2;
				end
				S_WR2: begin
					p2_q    <= pix;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						out_data_q.pixel_first  <= p1_q;
						out_data_q.pixel_second <= pair_q ? p2_q : 8'd0;
						out_data_q.pixel_count  <= cnt;
						out_data_q.column       <= 10'(col_q);
						out_data_q.row          <= 10'(row_q);
						out_data_q.last_of_run  <= lit_mode_q || (rem_q == 7'(cnt));
						out_data_q.plane_done   <= done;
						out_data_q.error        <= 1'b0;
						// Step the position; the end of the last row restarts the plane.
						if (done) begin
							col_q <= '0;
							row_q <= '0;
							lit_q <= '0;
						end else if (wrap) begin
							col_q <= '0;
							row_q <= row_next;
						end else begin
							col_q <= CW'(col_next);
						end
						if (lit_mode_q) begin
							if (!done) begin
								lit_q <= lit_q - 7'd1;
							end
							state_q <= S_IDLE;
						end else begin
							rem_q   <= rem_q - 7'(cnt);
							state_q <= (rem_q == 7'(cnt)) ? S_IDLE : S_RD1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign code.ready   = (state_q == S_IDLE);
	assign pixels.valid = out_valid_q;
	assign pixels.data  = out_data_q;

	// A word without pixels is only ever a rejected run.
	a_empty_is_error: assert property (@(posedge clk) disable iff (!arst_n)
		(pixels.valid && (pixels.data.pixel_count == 2'd0)) |-> pixels.data.error)
		else $error("pixel word without pixels that is not an error");

	// While a byte is in work the position stays inside the plane.
	a_pos_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> ((CW1'(col_q) < eff_w) && (row_q < eff_h)))
		else $error("decode position outside the plane");

	// A pair of pixels never runs past the row edge.
	a_pair_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && pair_q) |-> ((CW1'(col_q) + CW1'(1)) < eff_w))
		else $error("pixel pair straddles a row edge");

	// An error word and a plane completion never come together.
	a_err_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		pixels.valid |-> !(pixels.data.error && pixels.data.plane_done))
		else $error("error word flagged as plane completion");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int PLANE_MAX = 1024;
	localparam int RUN_MAX_WORDS = 64;
	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_STALL = 400;
	localparam int PHASE_ITEMS = 24;
	localparam logic RUN_COPY = 1'b0;
	localparam logic RUN_RESIDUAL = 1'b1;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [rupd_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [rupd_pkg::CFG_DATA_W-1:0] cfg_wdata;

	rupd_in_if code ();
	rupd_out_if pixels ();

	rle_up_prediction_plane_decoder_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.code(code),
		.pixels(pixels)
	);

	// Shadow of the decoder: registers, row above, position and owed residuals.
	logic [10:0] width_reg = rupd_pkg::PLANE_WIDTH_RST;
	logic [10:0] height_reg = rupd_pkg::PLANE_HEIGHT_RST;
	logic [7:0] above_row [PLANE_MAX];
	int unsigned pos_col = 0;
	int unsigned pos_row = 0;
	int unsigned residuals_owed = 0;
	rupd_pkg::out_word_t expected_words [$];

	int n_errors = 0;
	int items_sent = 0;
	int stall_len = 0;
	bit restart_due = 0;
	bit src_gaps = 0;
	bit sink_gaps = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// The register value 0 means one, anything past the maximum means the maximum.
	function automatic int unsigned eff_size(logic [10:0] v);
		if (v == 0) return 1;
		return (v > PLANE_MAX) ? PLANE_MAX : int'(v);
	endfunction

	function automatic void rewind_plane();
		pos_col = 0;
		pos_row = 0;
		residuals_owed = 0;
	endfunction

	function automatic logic [7:0] run_key(logic kind, int unsigned n);
		logic [7:0] k;
		k = 8'(n) & {1'b0, rupd_pkg::KEY_LENGTH_MASK};
		k[rupd_pkg::KEY_LITERAL_BIT] = kind;
		return k;
	endfunction

	// Row 0 predicts from zero; every pixel made replaces its column in the row store.
	function automatic logic [7:0] predict_pixel(logic [7:0] residual, int unsigned col);
		logic [7:0] up;
		logic [7:0] pix;
		up = (pos_row == 0) ? 8'd0 : above_row[col % PLANE_MAX];
		pix = up + residual;
		above_row[col % PLANE_MAX] = pix;
		return pix;
	endfunction

	// Moves past cnt pixels and tells whether the last row just completed.
	function automatic bit step_position(int unsigned cnt, int unsigned w, int unsigned h);
		pos_col += cnt;
		if (pos_col >= w) begin
			pos_col = 0;
			pos_row++;
			if (pos_row >= h) begin
				rewind_plane();
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic void push_word(int unsigned p1, int unsigned p2, int unsigned cnt,
			int unsigned col, int unsigned row, bit last, bit done, bit err);
		rupd_pkg::out_word_t wd;
		wd.pixel_first = 8'(p1);
		wd.pixel_second = 8'(p2);
		wd.pixel_count = 2'(cnt);
		wd.column = 10'(col);
		wd.row = 10'(row);
		wd.last_of_run = last;
		wd.plane_done = done;
		wd.error = err;
		expected_words.push_back(wd);
	endfunction

	// Queues the words one accepted byte produces. Returns 1 for a zero-length key,
	// which the decoder ignores.
	function automatic bit decode_byte(logic [7:0] b, logic rs);
		int unsigned w, h, n, room, to_edge, spill, remaining, c, r, cnt, k;
		logic [7:0] p1, p2;
		bit done;
		w = eff_size(width_reg);
		h = eff_size(height_reg);
		if (rs || pos_col >= w || pos_row >= h) rewind_plane();

		if (residuals_owed != 0) begin
			c = pos_col;
			r = pos_row;
			p1 = predict_pixel(b, c);
			residuals_owed--;
			done = step_position(1, w, h);
			push_word(p1, 0, 1, c, r, 1'b1, done, 1'b0);
			return 0;
		end

		n = b[6:0] & rupd_pkg::KEY_LENGTH_MASK;
		if (n == 0) return 1;
		room = w - pos_col;
		to_edge = (n < room) ? n : room;
		spill = n - to_edge;
		// A run that would wrap a full row or more, or wrap off the last row, is rejected.
		if (spill >= w || (spill != 0 && pos_row + 1 >= h)) begin
			push_word(0, 0, 0, pos_col, pos_row, 1'b1, 1'b0, 1'b1);
			rewind_plane();
			return 0;
		end
		if (b[rupd_pkg::KEY_LITERAL_BIT]) begin
			residuals_owed = n;
			return 0;
		end

		// Copy run: pairs of pixels from the row above, never straddling a row end.
		remaining = n;
		k = 0;
		while (remaining != 0 && k < RUN_MAX_WORDS) begin
			c = pos_col;
			r = pos_row;
			p2 = 8'd0;
			cnt = 1;
			p1 = predict_pixel(8'd0, c);
			if (remaining >= 2 && c + 1 < w) begin
				p2 = predict_pixel(8'd0, c + 1);
				cnt = 2;
			end
			remaining -= cnt;
			done = step_position(cnt, w, h);
			push_word(p1, p2, cnt, c, r, remaining == 0, done, 1'b0);
			k++;
		end
		return 0;
	endfunction

	task automatic compare_field(string name, logic [9:0] want, logic [9:0] got);
		if (got !== want) begin
			n_errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Each accepted pixel word is checked against the oldest prediction.
	always @(posedge clk) begin : check_words
		rupd_pkg::out_word_t want;
		rupd_pkg::out_word_t got;
		if (arst_n && pixels.valid === 1'b1 && pixels.ready === 1'b1) begin
			got = pixels.data;
			if (expected_words.size() == 0) begin
				n_errors++;
				$display("%0t: pixel word with none expected, expected nothing, got %p",
					$time, got);
			end else begin
				want = expected_words.pop_front();
				compare_field("pixel_first", want.pixel_first, got.pixel_first);
				compare_field("pixel_second", want.pixel_second, got.pixel_second);
				compare_field("pixel_count", want.pixel_count, got.pixel_count);
				compare_field("column", want.column, got.column);
				compare_field("row", want.row, got.row);
				compare_field("last_of_run", want.last_of_run, got.last_of_run);
				compare_field("plane_done", want.plane_done, got.plane_done);
				compare_field("error", want.error, got.error);
			end
		end
	end

	// Pixel receiver: a requested long hold-off first, else short random stalls.
	initial begin
		pixels.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_len != 0) begin
				pixels.ready <= 1'b0;
				repeat (stall_len) @(posedge clk);
				stall_len = 0;
				pixels.ready <= 1'b1;
			end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
				pixels.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				pixels.ready <= 1'b1;
			end else begin
				pixels.ready <= 1'b1;
			end
		end
	end

	// Offers one coded byte and predicts its words once the decoder takes it.
	// Valid stays high on return so that back-to-back bytes leave no gap.
	task automatic send_byte(logic [7:0] b, logic rs);
		rupd_pkg::in_word_t wd;
		wd.code_byte = b;
		wd.restart = rs | restart_due;
		restart_due = 0;
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			code.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		code.valid <= 1'b1;
		code.data <= wd;
		do @(posedge clk); while (code.ready !== 1'b1);
		if (!decode_byte(wd.code_byte, wd.restart)) items_sent++;
	endtask

	// Stops offering bytes, waits for every predicted word, then lets a byte that
	// makes no word finish inside the decoder.
	task automatic drain_results();
		code.valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A wider plane would read row-store columns never written, so the next byte
	// after a width increase starts a new plane.
	task automatic write_plane(logic [10:0] w, logic [10:0] h);
		if (eff_size(w) > eff_size(width_reg)) restart_due = 1;
		cfg_wen <= 1'b1;
		cfg_index <= rupd_pkg::REG_PLANE_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_index <= rupd_pkg::REG_PLANE_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_wen <= 1'b0;
		width_reg = w;
		height_reg = h;
	endtask

	// Mostly runs that fit the plane, with residuals for owed bytes, some restarts
	// and some arbitrary bytes that tend to overflow.
	task automatic send_random_item();
		int unsigned w, h, c, r, room, limit, n, roll;
		logic rs;
		roll = $urandom_range(0, 99);
		if (residuals_owed != 0 && roll < 92) begin
			send_byte(8'($urandom_range(0, 255)), 1'b0);
			return;
		end
		if (roll < 8) begin
			send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			return;
		end
		rs = (roll < 13);
		w = eff_size(width_reg);
		h = eff_size(height_reg);
		c = pos_col;
		r = pos_row;
		if (rs || c >= w || r >= h) begin
			c = 0;
			r = 0;
		end
		room = w - c;
		limit = (r + 1 < h) ? room + w - 1 : room;
		if (limit > 127) limit = 127;
		if ($urandom_range(0, 9) == 0) n = $urandom_range(1, limit);
		else n = $urandom_range(1, (limit < 10) ? limit : 10);
		send_byte(run_key(1'($urandom_range(0, 1)), n), rs);
	endtask

	// Zero-length keys, residual runs, a copy run that wraps, and a residual run
	// that completes the plane.
	task automatic test_basic_runs();
		drain_results();
		write_plane(4, 3);
		src_gaps = 1;
		sink_gaps = 1;
		send_byte(run_key(RUN_COPY, 0), 1'b0);
		send_byte(run_key(RUN_RESIDUAL, 0), 1'b0);
		send_byte(run_key(RUN_RESIDUAL, 4), 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7f, 1'b0);
		send_byte(run_key(RUN_RESIDUAL, 3), 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(run_key(RUN_COPY, 3), 1'b0);
		send_byte(run_key(RUN_RESIDUAL, 2), 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h81, 1'b0);
	endtask

	// A run that spills a full row, then the restart flag in the middle of a row.
	task automatic test_rejected_runs();
		send_byte(run_key(RUN_COPY, 2), 1'b0);
		send_byte(run_key(RUN_COPY, 8), 1'b0);
		send_byte(run_key(RUN_COPY, 3), 1'b0);
		send_byte(run_key(RUN_COPY, 2), 1'b1);
	endtask

	// Narrowing the plane so that the position falls outside it restarts silently.
	task automatic test_shrink_outside();
		drain_results();
		write_plane(8, 4);
		send_byte(run_key(RUN_COPY, 6), 1'b0);
		drain_results();
		write_plane(4, 4);
		send_byte(run_key(RUN_COPY, 1), 1'b0);
	endtask

	// The plane shrinks under a wrapping residual run, so it completes while
	// residuals are still owed; the next byte must be taken as a key.
	task automatic test_done_mid_residuals();
		drain_results();
		write_plane(4, 3);
		send_byte(run_key(RUN_COPY, 2), 1'b1);
		send_byte(run_key(RUN_RESIDUAL, 5), 1'b0);
		send_byte(8'h10, 1'b0);
		send_byte(8'h20, 1'b0);
		drain_results();
		write_plane(2, 2);
		send_byte(8'h30, 1'b0);
		send_byte(8'h40, 1'b0);
		send_byte(run_key(RUN_COPY, 1), 1'b0);
	endtask

	// Register values 0 and 2047, the longest copy run, and a wrap off a one-row plane.
	task automatic test_register_edges();
		drain_results();
		write_plane(11'd0, 11'd0);
		send_byte(run_key(RUN_COPY, 1), 1'b0);
		send_byte(run_key(RUN_COPY, 2), 1'b0);
		drain_results();
		write_plane(11'd2047, 11'd2047);
		send_byte(run_key(RUN_COPY, 127), 1'b0);
		drain_results();
		write_plane(5, 1);
		send_byte(run_key(RUN_COPY, 6), 1'b0);
	endtask

	// The receiver holds off long enough for the decoder to stall its input, then
	// the sender waits for every word before going on.
	task automatic test_output_backpressure();
		drain_results();
		write_plane(16, 8);
		src_gaps = 0;
		sink_gaps = 0;
		stall_len = LONG_STALL;
		repeat (25) send_random_item();
		drain_results();
	endtask

	// Random streams over several plane sizes; the last phase runs without idling.
	task automatic test_random_planes();
		logic [10:0] w, h;
		int start;
		for (int i = 0; i < 8; i++) begin
			case (i)
				0: begin w = 8; h = 4; end
				1: begin w = 0; h = 3; end
				2: begin w = 5; h = 1; end
				3: begin w = 33; h = 6; end
				4: begin w = 2047; h = 2; end
				5: begin w = 2; h = 2047; end
				6: begin w = 1024; h = 0; end
				default: begin w = 7; h = 3; end
			endcase
			drain_results();
			write_plane(w, h);
			src_gaps = (i != 7) && (i != 2);
			sink_gaps = (i != 7) && (i != 5);
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) send_random_item();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		code.valid = 1'b0;
		code.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_runs();
		test_rejected_runs();
		test_shrink_outside();
		test_done_mid_residuals();
		test_register_edges();
		test_output_backpressure();
		test_random_planes();

		drain_results();
		if (n_errors == 0) begin
			$display("[rle_up_prediction_plane_decoder_core] OK");
		end else begin
			$display("[rle_up_prediction_plane_decoder_core] ERROR");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#12_000_000;
		$display("[rle_up_prediction_plane_decoder_core] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/rupd_pkg.sv
hdl/rupd_if.sv
hdl/rupd_ram.sv
hdl/rle_up_prediction_plane_decoder_core.sv
bench/testbench.sv
